### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define SRSW_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define SRSW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg
// Types, constants and helpers of the selective-repeat sender window unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srsw_pkg;

   // window geometry
   localparam int WIN_DEPTH = 16;
   localparam int IDX_W     = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
   localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
   localparam int WL_W      = 5;
   localparam int LIM_W     = (CNT_W > WL_W) ? CNT_W : WL_W;

   // field widths
   localparam int SEQ_W  = 32;
   localparam int TO_W   = 16;
   localparam int OP_W   = 2;
   localparam int KIND_W = 3;

   // configuration
   localparam logic [TO_W-1:0] TIMEOUT_RESET = TO_W'(100);
   localparam logic [WL_W-1:0] WLIMIT_RESET  = WL_W'(8);
   localparam logic            CSR_TIMEOUT   = 1'b0;
   localparam logic            CSR_WLIMIT    = 1'b1;

   // opcodes
   localparam logic [OP_W-1:0] OP_TICK = 2'd0;
   localparam logic [OP_W-1:0] OP_ACK  = 2'd1;
   localparam logic [OP_W-1:0] OP_SEND = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_NEW     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_NACK    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REFUSED = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DONE    = 3'd4;

   // command queue
   localparam int Q_DEPTH = 2;
   localparam int QP_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int QC_W    = $clog2(Q_DEPTH + 1);

   typedef enum logic [1:0] {
      CLS_TICK,
      CLS_ACK,
      CLS_SEND,
      CLS_NONE
   } cls_type;

   typedef struct packed {
      cls_type              cls;
      logic [SEQ_W-1:0]     ack_seqno;
      logic [SEQ_W-1:0]     ack_next_expected;
      logic                 final_segment;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_type;

   typedef struct packed {
      logic [TO_W-1:0] timeout_ticks;
      logic [WL_W-1:0] window_limit;
   } csr_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_RETIRE,
      BK_NACK,
      BK_REFUSE,
      BK_FIN,
      BK_FLUSH
   } back_state_type;

   // ring slot at offset from head, modulo the window depth
   function automatic logic [IDX_W-1:0] slot_idx(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(head) + (CNT_W+1)'(off);
      if (s >= (CNT_W+1)'(WIN_DEPTH)) begin
         s = s - (CNT_W+1)'(WIN_DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

endpackage

### hw/rtl/selective_repeat_sender_window_unit.sv
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_unit
// Sender window of a selective-repeat transfer: sends, acks and timeouts.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken when start is high and busy is
//   low. req_op selects tick, acknowledgement or send request.
//   Result channel: each result is shown for one cycle with rsp_valid high;
//   rsp_last marks the final result of a command. The receiver cannot stall.
//   CSR port: csr_we writes timeout (index 0) or window limit (index 1);
//   write only while the unit is idle.
// Timing:
//   A two-entry queue takes commands while the back end works.
//   Ack, unknown op and plain send: FIN, then FLUSH; an in-range ack passes
//   RETIRE first. Refused send: RETIRE, NACK, REFUSE, FIN, FLUSH.
//   Tick: timeout scan, one ring entry per cycle (none if empty), FIN, FLUSH.
//   A result is held pending and leaves when the next is generated or in FLUSH.
// Reset:
//   Synchronous; empties the window and queue and restores CSR defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module selective_repeat_sender_window_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [srsw_pkg::OP_W-1:0]     req_op,
   input  logic [srsw_pkg::SEQ_W-1:0]    req_ack_seqno,
   input  logic [srsw_pkg::SEQ_W-1:0]    req_ack_next_expected,
   input  logic                          req_final_segment,
   output logic                          rsp_valid,
   output logic [srsw_pkg::KIND_W-1:0]   rsp_kind,
   output logic [srsw_pkg::SEQ_W-1:0]    rsp_seqno,
   output logic                          rsp_last,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [srsw_pkg::TO_W-1:0]     csr_wdata
);

   srsw_pkg::queue_type q;
   logic                q_pop;

   // command front end
   srsw_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_op                (req_op),
      .req_ack_seqno         (req_ack_seqno),
      .req_ack_next_expected (req_ack_next_expected),
      .req_final_segment     (req_final_segment),
      .q_out                 (q),
      .q_pop                 (q_pop)
   );

   // window back end
   srsw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_in      (q),
      .q_pop     (q_pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_kind  (rsp_kind),
      .rsp_seqno (rsp_seqno),
      .rsp_last  (rsp_last)
   );

endmodule

### hw/rtl/srsw_front.sv
// ----------------------------------------------------------------------------
// srsw_front
// Accepts commands, decodes the opcode and buffers them in a short queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srsw_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [srsw_pkg::OP_W-1:0]   req_op,
   input  logic [srsw_pkg::SEQ_W-1:0]  req_ack_seqno,
   input  logic [srsw_pkg::SEQ_W-1:0]  req_ack_next_expected,
   input  logic                        req_final_segment,
   output srsw_pkg::queue_type         q_out,
   input  logic                        q_pop
);

   srsw_pkg::item_type            mem_ff [srsw_pkg::Q_DEPTH];
   logic [srsw_pkg::QP_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [srsw_pkg::QP_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [srsw_pkg::QC_W-1:0]     cnt_ff, cnt_in;
   srsw_pkg::item_type            dec_item;
   logic                          push;

   // opcode classification
   always_comb begin
      dec_item.ack_seqno         = req_ack_seqno;
      dec_item.ack_next_expected = req_ack_next_expected;
      dec_item.final_segment     = req_final_segment;
      unique case (req_op)
         srsw_pkg::OP_TICK: dec_item.cls = srsw_pkg::CLS_TICK;
         srsw_pkg::OP_ACK:  dec_item.cls = srsw_pkg::CLS_ACK;
         srsw_pkg::OP_SEND: dec_item.cls = srsw_pkg::CLS_SEND;
         default:           dec_item.cls = srsw_pkg::CLS_NONE;
      endcase
   end

   assign busy  = (cnt_ff == srsw_pkg::QC_W'(srsw_pkg::Q_DEPTH));
   assign push  = start && !busy;
   assign q_out.valid = (cnt_ff != '0);
   assign q_out.item  = mem_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == srsw_pkg::QP_W'(srsw_pkg::Q_DEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == srsw_pkg::QP_W'(srsw_pkg::Q_DEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= dec_item;
      end
   end

   `SRSW_ASSERT_NEXT(a_push_visible, clock, reset, push, q_out.valid)
   `SRSW_ASSERT(a_pop_nonempty, clock, reset, q_pop |-> q_out.valid)
   `SRSW_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= srsw_pkg::QC_W'(srsw_pkg::Q_DEPTH))

endmodule

### hw/rtl/srsw_back.sv
// ----------------------------------------------------------------------------
// srsw_back
// Window state, timeout scan, ack handling and result sequencing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srsw_back (
   input  logic                          clock,
   input  logic                          reset,
   input  srsw_pkg::queue_type           q_in,
   output logic                          q_pop,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [srsw_pkg::TO_W-1:0]     csr_wdata,
   output logic                          rsp_valid,
   output logic [srsw_pkg::KIND_W-1:0]   rsp_kind,
   output logic [srsw_pkg::SEQ_W-1:0]    rsp_seqno,
   output logic                          rsp_last
);

   localparam int SEQ_W = srsw_pkg::SEQ_W;
   localparam int CNT_W = srsw_pkg::CNT_W;
   localparam int IDX_W = srsw_pkg::IDX_W;
   localparam int LIM_W = srsw_pkg::LIM_W;

   srsw_pkg::back_state_type state_ff, state_in;
   srsw_pkg::cls_type        cls_ff, cls_in;
   srsw_pkg::csr_type        csr_ff;

   // window entries
   logic             acked_ff [srsw_pkg::WIN_DEPTH];
   logic [SEQ_W-1:0] sent_ff  [srsw_pkg::WIN_DEPTH];
   logic             ack_we;
   logic [IDX_W-1:0] ack_wa;
   logic             ack_wd;
   logic             sent_we;
   logic [IDX_W-1:0] sent_wa;

   // scalar state
   logic [SEQ_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [SEQ_W-1:0] next_seq_ff, next_seq_in;
   logic [SEQ_W-1:0] next_exp_ff, next_exp_in;
   logic             nack_ff, nack_in;
   logic             fsent_ff, fsent_in;
   logic             done_ff, done_in;
   logic [SEQ_W-1:0] time_ff, time_in;
   logic [CNT_W-1:0] scan_ff, scan_in;

   // pending result register
   logic                        pend_v_ff, pend_v_in;
   logic [srsw_pkg::KIND_W-1:0] pend_k_ff, pend_k_in;
   logic [SEQ_W-1:0]            pend_s_ff, pend_s_in;

   logic                        gen_v;
   logic [srsw_pkg::KIND_W-1:0] gen_k;
   logic [SEQ_W-1:0]            gen_s;

   // decode helpers
   logic [LIM_W-1:0] lim;
   logic             full;
   logic [SEQ_W-1:0] ack_d;
   logic             ack_in_range;
   logic [IDX_W-1:0] scan_slot;
   logic [SEQ_W-1:0] age;
   logic [SEQ_W-1:0] ret_n;
   logic [CNT_W-1:0] ret_k;
   logic             scan_last;

   assign lim  = (csr_ff.window_limit > LIM_W'(srsw_pkg::WIN_DEPTH))
                 ? LIM_W'(srsw_pkg::WIN_DEPTH) : LIM_W'(csr_ff.window_limit);
   assign full = (LIM_W'(count_ff) >= lim);
   assign ack_d = q_in.item.ack_seqno - front_ff;
   assign ack_in_range = (count_ff != '0) && (q_in.item.ack_seqno >= front_ff)
                         && (ack_d < SEQ_W'(count_ff));
   assign scan_slot = srsw_pkg::slot_idx(head_ff, scan_ff);
   assign age       = time_ff - sent_ff[scan_slot];
   assign ret_n     = next_exp_ff - front_ff;
   assign ret_k     = ((count_ff == '0) || (next_exp_ff <= front_ff)) ? '0
                      : ((ret_n >= SEQ_W'(count_ff)) ? count_ff : ret_n[CNT_W-1:0]);
   assign scan_last = (scan_ff + 1'b1 >= count_ff);
   assign q_pop     = (state_ff == srsw_pkg::BK_IDLE) && q_in.valid;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srsw_pkg::BK_IDLE: begin
            if (q_in.valid) begin
               unique case (q_in.item.cls)
                  srsw_pkg::CLS_TICK:
                     state_in = (count_ff == '0) ? srsw_pkg::BK_FIN : srsw_pkg::BK_SCAN;
                  srsw_pkg::CLS_ACK:
                     state_in = ack_in_range ? srsw_pkg::BK_RETIRE : srsw_pkg::BK_FIN;
                  srsw_pkg::CLS_SEND:
                     state_in = full ? srsw_pkg::BK_RETIRE : srsw_pkg::BK_FIN;
                  default:
                     state_in = srsw_pkg::BK_FIN;
               endcase
            end
         end
         srsw_pkg::BK_SCAN:   state_in = scan_last ? srsw_pkg::BK_FIN : srsw_pkg::BK_SCAN;
         srsw_pkg::BK_RETIRE: state_in = (cls_ff == srsw_pkg::CLS_SEND) ? srsw_pkg::BK_NACK
                                         : srsw_pkg::BK_FIN;
         srsw_pkg::BK_NACK:   state_in = srsw_pkg::BK_REFUSE;
         srsw_pkg::BK_REFUSE: state_in = srsw_pkg::BK_FIN;
         srsw_pkg::BK_FIN:    state_in = srsw_pkg::BK_FLUSH;
         srsw_pkg::BK_FLUSH:  state_in = srsw_pkg::BK_IDLE;
         default:             state_in = srsw_pkg::BK_IDLE;
      endcase
   end

   // datapath and result generation
   always_comb begin
      front_in    = front_ff;
      count_in    = count_ff;
      head_in     = head_ff;
      next_seq_in = next_seq_ff;
      next_exp_in = next_exp_ff;
      nack_in     = nack_ff;
      fsent_in    = fsent_ff;
      done_in     = done_ff;
      time_in     = time_ff;
      scan_in     = scan_ff;
      cls_in      = cls_ff;
      ack_we      = 1'b0;
      ack_wa      = head_ff;
      ack_wd      = 1'b0;
      sent_we     = 1'b0;
      sent_wa     = head_ff;
      gen_v       = 1'b0;
      gen_k       = srsw_pkg::KIND_NEW;
      gen_s       = next_seq_ff;
      unique case (state_ff)
         srsw_pkg::BK_IDLE: begin
            if (q_in.valid) begin
               cls_in = q_in.item.cls;
               unique case (q_in.item.cls)
                  srsw_pkg::CLS_TICK: begin
                     time_in = time_ff + 1'b1;
                     scan_in = '0;
                  end
                  srsw_pkg::CLS_ACK: begin
                     if (ack_in_range) begin
                        ack_we = 1'b1;
                        ack_wa = srsw_pkg::slot_idx(head_ff, ack_d[CNT_W-1:0]);
                        ack_wd = 1'b1;
                        if (q_in.item.ack_next_expected > next_exp_ff) begin
                           next_exp_in = q_in.item.ack_next_expected;
                           nack_in     = 1'b0;
                        end
                     end
                  end
                  srsw_pkg::CLS_SEND: begin
                     if (!full && !fsent_ff) begin
                        ack_we      = 1'b1;
                        ack_wa      = srsw_pkg::slot_idx(head_ff, count_ff);
                        ack_wd      = 1'b0;
                        sent_we     = 1'b1;
                        sent_wa     = srsw_pkg::slot_idx(head_ff, count_ff);
                        next_seq_in = next_seq_ff + 1'b1;
                        count_in    = count_ff + 1'b1;
                        if (count_ff == '0) begin
                           front_in = next_seq_ff;
                        end
                        if (q_in.item.final_segment) begin
                           fsent_in = 1'b1;
                        end
                        gen_v = 1'b1;
                        gen_k = srsw_pkg::KIND_NEW;
                        gen_s = next_seq_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         srsw_pkg::BK_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (!acked_ff[scan_slot] && (age > SEQ_W'(csr_ff.timeout_ticks))) begin
               sent_we = 1'b1;
               sent_wa = scan_slot;
               gen_v   = 1'b1;
               gen_k   = srsw_pkg::KIND_TIMEOUT;
               gen_s   = front_ff + SEQ_W'(scan_ff);
            end
         end
         srsw_pkg::BK_RETIRE: begin
            // pop front entries that lie below next expected
            head_in  = srsw_pkg::slot_idx(head_ff, ret_k);
            front_in = front_ff + SEQ_W'(ret_k);
            count_in = count_ff - ret_k;
         end
         srsw_pkg::BK_NACK: begin
            if ((count_ff != '0) && !nack_ff) begin
               sent_we = 1'b1;
               sent_wa = head_ff;
               nack_in = 1'b1;
               gen_v   = 1'b1;
               gen_k   = srsw_pkg::KIND_NACK;
               gen_s   = front_ff;
            end
         end
         srsw_pkg::BK_REFUSE: begin
            gen_v = 1'b1;
            gen_k = srsw_pkg::KIND_REFUSED;
            gen_s = next_seq_ff;
         end
         srsw_pkg::BK_FIN: begin
            if (fsent_ff && (count_ff == '0) && !done_ff) begin
               done_in = 1'b1;
               gen_v   = 1'b1;
               gen_k   = srsw_pkg::KIND_DONE;
               gen_s   = next_seq_ff;
            end
         end
         default: ;
      endcase
   end

   // pending register: a result leaves once the next one is known, or in FLUSH
   always_comb begin
      pend_v_in = pend_v_ff;
      pend_k_in = pend_k_ff;
      pend_s_in = pend_s_ff;
      if (state_ff == srsw_pkg::BK_FLUSH) begin
         pend_v_in = 1'b0;
      end else if (gen_v) begin
         pend_v_in = 1'b1;
         pend_k_in = gen_k;
         pend_s_in = gen_s;
      end
   end

   // result outputs
   always_comb begin
      rsp_valid = pend_v_ff && (gen_v || (state_ff == srsw_pkg::BK_FLUSH));
      rsp_kind  = pend_k_ff;
      rsp_seqno = pend_s_ff;
      rsp_last  = rsp_valid && (state_ff == srsw_pkg::BK_FLUSH);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= srsw_pkg::BK_IDLE;
         cls_ff      <= srsw_pkg::CLS_NONE;
         front_ff    <= '0;
         count_ff    <= '0;
         head_ff     <= '0;
         next_seq_ff <= '0;
         next_exp_ff <= '0;
         nack_ff     <= 1'b0;
         fsent_ff    <= 1'b0;
         done_ff     <= 1'b0;
         time_ff     <= '0;
         scan_ff     <= '0;
         pend_v_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cls_ff      <= cls_in;
         front_ff    <= front_in;
         count_ff    <= count_in;
         head_ff     <= head_in;
         next_seq_ff <= next_seq_in;
         next_exp_ff <= next_exp_in;
         nack_ff     <= nack_in;
         fsent_ff    <= fsent_in;
         done_ff     <= done_in;
         time_ff     <= time_in;
         scan_ff     <= scan_in;
         pend_v_ff   <= pend_v_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.timeout_ticks <= srsw_pkg::TIMEOUT_RESET;
         csr_ff.window_limit  <= srsw_pkg::WLIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            srsw_pkg::CSR_TIMEOUT: csr_ff.timeout_ticks <= csr_wdata;
            srsw_pkg::CSR_WLIMIT:  csr_ff.window_limit  <= csr_wdata[srsw_pkg::WL_W-1:0];
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_k_ff <= pend_k_in;
      pend_s_ff <= pend_s_in;
      if (ack_we) begin
         acked_ff[ack_wa] <= ack_wd;
      end
      if (sent_we) begin
         sent_ff[sent_wa] <= time_ff;
      end
   end

   `SRSW_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(srsw_pkg::WIN_DEPTH))
   `SRSW_ASSERT(a_idle_quiet, clock, reset, (state_ff == srsw_pkg::BK_IDLE) |-> !pend_v_ff)
   `SRSW_ASSERT_NEXT(a_flush_idle, clock, reset, state_ff == srsw_pkg::BK_FLUSH,
                     state_ff == srsw_pkg::BK_IDLE && !pend_v_ff)

endmodule
